// ===== rtl/otoq_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle table query package
// Shared types, codes and constants of the obstacle table query block.
// ----------------------------------------------------------------------------
`default_nettype none

package otoq_pkg;

    localparam int MAX_OBSTACLES_DEF = 32;
    localparam int CRD_W = 24;
    localparam int RAD_W = 16;
    localparam int KEY_W = 16;

    localparam logic [RAD_W-1:0] POINT_RADIUS = 16'd256;

    localparam logic [2:0] MODE_ADD_ENT  = 3'd0;
    localparam logic [2:0] MODE_SKIP_ENT = 3'd1;
    localparam logic [2:0] MODE_ADD_PT   = 3'd2;
    localparam logic [2:0] MODE_MOVE_ENT = 3'd3;
    localparam logic [2:0] MODE_PT_QRY   = 3'd4;
    localparam logic [2:0] MODE_SEG_QRY  = 3'd5;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NO_KEY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_PT_ADD,
        S_SETUP,
        S_SQRT,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_QQ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] z;
        logic [RAD_W-1:0] rad;
        logic [KEY_W-1:0] id;
        logic             skip;
    } t_ent;

    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] z;
    } t_pt;

endpackage

`default_nettype wire

// ===== rtl/obstacle_table_obstruction_query_top.sv =====
// ----------------------------------------------------------------------------
// Obstacle table obstruction query
// Entity and point obstacle tables with point and segment overlap queries.
// ----------------------------------------------------------------------------
// One word is taken at a time. An edit of the entity table searches the keys
// one stored entity after another, reading and then comparing each; adding a
// point writes the next free slot of the point table. A point query sets up,
// then scans the live obstacles, passing quickly over skipped entities. A
// segment query also takes the root of the squared length and does a
// bit-serial projection divide per obstacle. The multiply steps share one
// 26 by 26 multiplier, and each obstacle memory has one read port. A
// finished word waits in the output register while the next word is taken.
`default_nettype none

module obstacle_table_obstruction_query_top #(
    parameter int MAX_OBSTACLES = otoq_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_mode,
    input  logic [otoq_pkg::KEY_W-1:0]          i_entity_key,
    input  logic signed [otoq_pkg::CRD_W-1:0]   i_pos_x,
    input  logic signed [otoq_pkg::CRD_W-1:0]   i_pos_y,
    input  logic signed [otoq_pkg::CRD_W-1:0]   i_pos_z,
    input  logic signed [otoq_pkg::CRD_W-1:0]   i_end_x,
    input  logic signed [otoq_pkg::CRD_W-1:0]   i_end_y,
    input  logic signed [otoq_pkg::CRD_W-1:0]   i_end_z,
    input  logic [otoq_pkg::RAD_W-1:0]          i_radius,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [5:0]                          o_slot,
    output logic                                o_hit,
    output logic                                o_hit_is_point,
    output logic signed [otoq_pkg::CRD_W-1:0]   o_hit_x,
    output logic signed [otoq_pkg::CRD_W-1:0]   o_hit_y,
    output logic signed [otoq_pkg::CRD_W-1:0]   o_hit_z,
    output logic [otoq_pkg::RAD_W-1:0]          o_hit_radius
);
    import otoq_pkg::*;

    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NW = $clog2(MAX_OBSTACLES + 1);
    localparam int IW = $clog2(2 * MAX_OBSTACLES + 1);

    t_ent r_ent_mem [MAX_OBSTACLES];
    t_pt  r_pt_mem  [MAX_OBSTACLES];
    t_ent r_ent_q;
    t_pt  r_pt_q;

    t_state r_state, n_state;

    logic [NW-1:0] r_ent_cnt, r_pt_cnt;
    logic [2:0]       r_mode;
    logic [KEY_W-1:0] r_key;
    logic [RAD_W-1:0] r_rq;
    logic signed [CRD_W-1:0] r_s [3];
    logic signed [CRD_W:0]   r_l [3];
    logic signed [CRD_W:0]   r_o [3];
    logic [CRD_W-1:0] r_hc [3];
    logic [RAD_W-1:0] r_rt;
    logic             r_is_pt;
    logic             r_in_pt;
    logic             r_seg;
    logic [IW-1:0]    r_idx;
    logic [3:0]       r_step;
    logic [5:0]       r_bit;

    logic signed [51:0] r_prod;
    logic [49:0]        r_lsq;
    logic [31:0]        r_rq2, r_rt2;
    logic [49:0]        r_osq;
    logic signed [50:0] r_dot;
    logic [24:0]        r_root;
    logic [25:0]        r_rem;
    logic [49:0]        r_mag;
    logic [49:0]        r_quo;
    logic [24:0]        r_drem;
    logic               r_dneg;

    logic [1:0]       r_res_status;
    logic [5:0]       r_res_slot;
    logic             r_res_hit, r_res_is_pt;
    logic [CRD_W-1:0] r_res_x, r_res_y, r_res_z;
    logic [RAD_W-1:0] r_res_rad;

    logic             r_o_valid;
    logic [1:0]       r_o_status;
    logic [5:0]       r_o_slot;
    logic             r_o_hit, r_o_is_pt;
    logic [CRD_W-1:0] r_o_x, r_o_y, r_o_z;
    logic [RAD_W-1:0] r_o_rad;

    logic          in_acc, out_free;
    logic [IW-1:0] total, next_idx, pt_off;
    logic          last, ent_full, pt_full, key_match, not_found, ld_skip, seg_ok;
    logic          chk_hit;
    logic          ent_we, pt_we;
    logic [AW-1:0] ent_wa, ent_ra, pt_wa, pt_ra;
    t_ent          ent_wd;
    t_pt           pt_wd;

    logic signed [25:0] mul_a, mul_b;

    logic [5:0]  sq_pos;
    logic [27:0] sq_t, sq_trial;
    logic        sq_ge;
    logic [25:0] dv_t;
    logic        dv_ge;

    logic [32:0]        thr;
    logic [49:0]        qq, dd;
    logic               q_big;
    logic [16:0]        rr;
    logic signed [51:0] q52, sc, rs, len_s;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_o_valid || !i_out_stall;
    assign total     = IW'(r_ent_cnt) + IW'(r_pt_cnt);
    assign next_idx  = r_idx + IW'(1);
    assign last      = (next_idx == total);
    assign pt_off    = r_idx - IW'(r_ent_cnt);
    assign ent_full  = (r_ent_cnt == NW'(MAX_OBSTACLES));
    assign pt_full   = (r_pt_cnt == NW'(MAX_OBSTACLES));
    assign key_match = (r_ent_q.id == r_key);
    assign not_found = (r_idx == IW'(r_ent_cnt));
    assign ld_skip   = !r_in_pt && r_ent_q.skip;
    assign seg_ok    = (r_mode == MODE_SEG_QRY) && (r_lsq != '0);

    assign sq_pos   = {r_bit[4:0] - 5'd1, 1'b0};
    assign sq_t     = {r_rem, r_lsq[sq_pos +: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    assign dv_t  = {r_drem, r_mag[49]};
    assign dv_ge = (dv_t >= {1'b0, r_root});

    assign thr   = {1'b0, r_rq2} + {1'b0, r_rt2};
    assign qq    = r_prod[49:0];
    assign q_big = |r_quo[49:25];
    assign dd    = (q_big || qq >= r_osq) ? '0 : r_osq - qq;
    assign rr    = {1'b0, r_rq} + {1'b0, r_rt};
    assign q52   = $signed({2'b00, r_quo});
    assign sc    = r_dneg ? -q52 : q52;
    assign rs    = $signed({35'd0, rr});
    assign len_s = $signed({27'd0, r_root});

    always_comb begin
        if (r_seg) begin
            chk_hit = (sc > -rs) && (sc < len_s + rs) && (dd < 50'(thr));
        end else begin
            chk_hit = (r_osq < 50'(thr));
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SETUP: begin
                case (r_step)
                    4'd0: begin mul_a = 26'(r_l[0]); mul_b = 26'(r_l[0]); end
                    4'd1: begin mul_a = 26'(r_l[1]); mul_b = 26'(r_l[1]); end
                    4'd2: begin mul_a = 26'(r_l[2]); mul_b = 26'(r_l[2]); end
                    4'd3: begin
                        mul_a = $signed({10'd0, r_rq});
                        mul_b = $signed({10'd0, r_rq});
                    end
                    default: ;
                endcase
            end
            S_MUL: begin
                case (r_step)
                    4'd0: begin mul_a = 26'(r_o[0]); mul_b = 26'(r_o[0]); end
                    4'd1: begin
                        mul_a = r_seg ? 26'(r_o[1]) : '0;
                        mul_b = 26'(r_o[1]);
                    end
                    4'd2: begin mul_a = 26'(r_o[2]); mul_b = 26'(r_o[2]); end
                    4'd3: begin
                        mul_a = $signed({10'd0, r_rt});
                        mul_b = $signed({10'd0, r_rt});
                    end
                    4'd4: begin mul_a = 26'(r_l[0]); mul_b = 26'(r_o[0]); end
                    4'd5: begin mul_a = 26'(r_l[1]); mul_b = 26'(r_o[1]); end
                    4'd6: begin mul_a = 26'(r_l[2]); mul_b = 26'(r_o[2]); end
                    default: ;
                endcase
            end
            S_QQ: begin
                mul_a = $signed({1'b0, r_quo[24:0]});
                mul_b = $signed({1'b0, r_quo[24:0]});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_mode) inside
                        MODE_ADD_ENT, MODE_SKIP_ENT, MODE_MOVE_ENT: n_state = S_FIND_RD;
                        MODE_ADD_PT:                  n_state = S_PT_ADD;
                        MODE_PT_QRY, MODE_SEG_QRY:    n_state = S_SETUP;
                        default:                      n_state = S_DONE;
                    endcase
                end
            end
            S_FIND_RD:  n_state = not_found ? S_DONE : S_FIND_CMP;
            S_FIND_CMP: n_state = key_match ? S_DONE : S_FIND_RD;
            S_PT_ADD:   n_state = S_DONE;
            S_SETUP: begin
                if (r_step == 4'd4) begin
                    if (seg_ok) begin
                        n_state = S_SQRT;
                    end else begin
                        n_state = (total == '0) ? S_DONE : S_FETCH;
                    end
                end
            end
            S_SQRT: begin
                if (r_bit == 6'd1) begin
                    n_state = (total == '0) ? S_DONE : S_FETCH;
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD: begin
                if (ld_skip) begin
                    n_state = last ? S_DONE : S_FETCH;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_step == 4'd8) begin
                    n_state = r_seg ? S_DIV : S_CHECK;
                end
            end
            S_DIV:   n_state = (r_bit == 6'd1) ? S_QQ : S_DIV;
            S_QQ:    n_state = S_CHECK;
            S_CHECK: n_state = (chk_hit || last) ? S_DONE : S_FETCH;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        ent_we = 1'b0;
        ent_wa = r_idx[AW-1:0];
        ent_wd = r_ent_q;
        pt_we  = 1'b0;
        pt_wa  = r_pt_cnt[AW-1:0];
        pt_wd  = '{x: r_s[0], y: r_s[1], z: r_s[2]};
        ent_ra = (r_idx < IW'(r_ent_cnt)) ? r_idx[AW-1:0] : '0;
        pt_ra  = (r_idx < IW'(r_ent_cnt)) ? '0 : pt_off[AW-1:0];
        unique case (r_state)
            S_FIND_RD: begin
                if (not_found && r_mode == MODE_ADD_ENT && !ent_full) begin
                    ent_we = 1'b1;
                    ent_wa = r_ent_cnt[AW-1:0];
                    ent_wd = '{x: r_s[0], y: r_s[1], z: r_s[2], rad: r_rq,
                               id: r_key, skip: 1'b0};
                end
            end
            S_FIND_CMP: begin
                if (key_match) begin
                    ent_we = 1'b1;
                    case (r_mode)
                        MODE_ADD_ENT:  ent_wd.skip = 1'b0;
                        MODE_SKIP_ENT: ent_wd.skip = 1'b1;
                        default: begin
                            ent_wd.x = r_s[0];
                            ent_wd.y = r_s[1];
                            ent_wd.z = r_s[2];
                        end
                    endcase
                end
            end
            S_PT_ADD: pt_we = !pt_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_wa] <= ent_wd;
        end
        if (pt_we) begin
            r_pt_mem[pt_wa] <= pt_wd;
        end
        r_ent_q <= r_ent_mem[ent_ra];
        r_pt_q  <= r_pt_mem[pt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ent_cnt <= '0;
            r_pt_cnt  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode <= i_mode;
                        r_key  <= i_entity_key;
                        r_rq   <= i_radius;
                        r_s[0] <= i_pos_x;
                        r_s[1] <= i_pos_y;
                        r_s[2] <= i_pos_z;
                        r_l[0] <= 25'(i_end_x) - 25'(i_pos_x);
                        r_l[1] <= 25'(i_end_y) - 25'(i_pos_y);
                        r_l[2] <= 25'(i_end_z) - 25'(i_pos_z);
                        r_idx  <= '0;
                        r_step <= '0;
                        r_lsq  <= '0;
                        r_seg  <= 1'b0;
                        r_res_status <= ST_DONE;
                        r_res_slot   <= '0;
                        r_res_hit    <= 1'b0;
                        r_res_is_pt  <= 1'b0;
                        r_res_x      <= '0;
                        r_res_y      <= '0;
                        r_res_z      <= '0;
                        r_res_rad    <= '0;
                    end
                end
                S_FIND_RD: begin
                    if (not_found) begin
                        if (r_mode == MODE_ADD_ENT) begin
                            if (ent_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_slot <= 6'(r_ent_cnt);
                                r_ent_cnt  <= r_ent_cnt + NW'(1);
                            end
                        end else begin
                            r_res_status <= ST_NO_KEY;
                        end
                    end
                end
                S_FIND_CMP: begin
                    if (key_match) begin
                        r_res_slot <= (r_mode == MODE_ADD_ENT) ? 6'(r_ent_cnt) : 6'(r_idx);
                    end else begin
                        r_idx <= next_idx;
                    end
                end
                S_PT_ADD: begin
                    if (pt_full) begin
                        r_res_status <= ST_FULL;
                    end else begin
                        r_res_slot <= 6'(r_pt_cnt);
                        r_pt_cnt   <= r_pt_cnt + NW'(1);
                    end
                end
                S_SETUP: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd1, 4'd2, 4'd3: r_lsq <= r_lsq + r_prod[49:0];
                        4'd4: begin
                            r_rq2  <= r_prod[31:0];
                            r_seg  <= seg_ok;
                            r_rem  <= '0;
                            r_root <= '0;
                            r_bit  <= 6'd25;
                        end
                        default: ;
                    endcase
                end
                S_SQRT: begin
                    r_rem  <= sq_ge ? 26'(sq_t - sq_trial) : 26'(sq_t);
                    r_root <= {r_root[23:0], sq_ge};
                    r_bit  <= r_bit - 6'd1;
                end
                S_FETCH: begin
                    r_in_pt <= (r_idx >= IW'(r_ent_cnt));
                end
                S_LOAD: begin
                    if (r_in_pt) begin
                        r_hc[0] <= r_pt_q.x;
                        r_hc[1] <= r_pt_q.y;
                        r_hc[2] <= r_pt_q.z;
                        r_o[0]  <= 25'($signed(r_pt_q.x)) - 25'(r_s[0]);
                        r_o[1]  <= 25'($signed(r_pt_q.y)) - 25'(r_s[1]);
                        r_o[2]  <= 25'($signed(r_pt_q.z)) - 25'(r_s[2]);
                        r_rt    <= POINT_RADIUS;
                    end else begin
                        r_hc[0] <= r_ent_q.x;
                        r_hc[1] <= r_ent_q.y;
                        r_hc[2] <= r_ent_q.z;
                        r_o[0]  <= 25'($signed(r_ent_q.x)) - 25'(r_s[0]);
                        r_o[1]  <= 25'($signed(r_ent_q.y)) - 25'(r_s[1]);
                        r_o[2]  <= 25'($signed(r_ent_q.z)) - 25'(r_s[2]);
                        r_rt    <= r_ent_q.rad;
                    end
                    r_is_pt <= r_in_pt;
                    r_osq   <= '0;
                    r_dot   <= '0;
                    r_step  <= '0;
                    if (ld_skip) begin
                        r_idx <= next_idx;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd1, 4'd2, 4'd3: r_osq <= r_osq + r_prod[49:0];
                        4'd4:             r_rt2 <= r_prod[31:0];
                        4'd5, 4'd6, 4'd7: r_dot <= r_dot + 51'(r_prod);
                        4'd8: begin
                            r_mag  <= r_dot[50] ? 50'(-r_dot) : r_dot[49:0];
                            r_dneg <= r_dot[50];
                            r_drem <= '0;
                            r_quo  <= '0;
                            r_bit  <= 6'd50;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    r_drem <= dv_ge ? 25'(dv_t - {1'b0, r_root}) : 25'(dv_t);
                    r_mag  <= {r_mag[48:0], 1'b0};
                    r_quo  <= {r_quo[48:0], dv_ge};
                    r_bit  <= r_bit - 6'd1;
                end
                S_QQ: ;
                S_CHECK: begin
                    if (chk_hit) begin
                        r_res_hit   <= 1'b1;
                        r_res_is_pt <= r_is_pt;
                        r_res_x     <= r_hc[0];
                        r_res_y     <= r_hc[1];
                        r_res_z     <= r_hc[2];
                        r_res_rad   <= r_rt;
                    end else begin
                        r_idx <= next_idx;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_status <= r_res_status;
                        r_o_slot   <= r_res_slot;
                        r_o_hit    <= r_res_hit;
                        r_o_is_pt  <= r_res_is_pt;
                        r_o_x      <= r_res_x;
                        r_o_y      <= r_res_y;
                        r_o_z      <= r_res_z;
                        r_o_rad    <= r_res_rad;
                    end
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_slot         = r_o_slot;
    assign o_hit          = r_o_hit;
    assign o_hit_is_point = r_o_is_pt;
    assign o_hit_x        = r_o_x;
    assign o_hit_y        = r_o_y;
    assign o_hit_z        = r_o_z;
    assign o_hit_radius   = r_o_rad;

endmodule

`default_nettype wire

// ===== rtl/otoq_checker.sv =====
// ----------------------------------------------------------------------------
// Obstacle table query checker
// Port-level assertions on the obstacle table query block.
// ----------------------------------------------------------------------------
`default_nettype none

module otoq_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_stall,
    input wire                               o_out_valid,
    input wire                               i_out_stall,
    input wire [1:0]                         o_status,
    input wire [5:0]                         o_slot,
    input wire                               o_hit,
    input wire                               o_hit_is_point,
    input wire [otoq_pkg::RAD_W-1:0]         o_hit_radius
);
    import otoq_pkg::*;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while the previous word is still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_slot) && $stable(o_hit))
        else $error("stalled output word changed");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_status == ST_DONE && o_slot == 6'd0)
        else $error("hit word carries edit status or slot");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> !o_hit_is_point && o_hit_radius == '0)
        else $error("miss word carries obstacle fields");

    a_point_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit_is_point |-> o_hit && o_hit_radius == POINT_RADIUS)
        else $error("point hit with wrong radius");

endmodule

bind obstacle_table_obstruction_query_top otoq_checker u_otoq_checker (.*);

`default_nettype wire
